FILE: hdl/sobel_edge_magnitude_rgb_macros.svh
// Assertion macros shared by the edge magnitude RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SEM_ASSERT_NOW(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("same-cycle check failed");

// Condition implies consequence in the next cycle.
`define SEM_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hdl/sem_pkg.sv
// Types and constants for the Sobel edge magnitude block.
// No dependencies.
`default_nettype none
package sem_pkg;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 24;
	localparam int GRAD_W = 11;
	localparam int SUM_W  = 21;
	localparam int ROW_W  = 16;
	localparam int COL_W  = 11;
	localparam int FW_W   = 12;
	localparam int FH_W   = 16;
	localparam int CFG_W  = 16;

	localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
	localparam logic [CH_W-1:0]  MAG_MAX   = 8'd255;
	localparam logic [CH_W-1:0]  ROOT_TOP  = 8'd128;
	localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RESET = 16'd480;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [2:0][PIX_W-1:0] column_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_GRAD,
		ST_SQUARE,
		ST_ROOT,
		ST_EMIT
	} state_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} root_ctl_t;
endpackage
`default_nettype wire

FILE: hdl/sem_ifs.sv
// Valid/ready channel interfaces for pixels in and results out.
// Depends on sem_pkg.
`default_nettype none
interface sem_pix_if import sem_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             run_last;
	logic             frame_done;
	modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
		run_last, frame_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
		run_last, frame_done, output ready);
endinterface
`default_nettype wire

FILE: hdl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/sem_col_cell.sv
// One column of the 3x3 window: three pixels, handed on to the left neighbour.
// Depends on sem_pkg.
`default_nettype none
module sem_col_cell import sem_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire column_t   d,
	output column_t        q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ctl.shift) begin
			q <= ctl.clear ? '0 : d;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sem_root.sv
// Gradient magnitude lane: squares and sums gx and gy, then a bit-per-cycle
// square root with round to nearest and saturation. Depends on sem_pkg.
`default_nettype none
module sem_root import sem_pkg::*; (
	input  wire logic                     clk,
	input  wire root_ctl_t                ctl,
	input  wire logic signed [GRAD_W-1:0] gx,
	input  wire logic signed [GRAD_W-1:0] gy,
	output logic [CH_W-1:0]               mag
);
	logic [SUM_W-1:0]     s_q;
	logic [CH_W-1:0]      n_q;
	logic [CH_W-1:0]      bit_q;
	logic [CH_W-1:0]      t;
	logic [2*CH_W-1:0]    tt;
	logic [2*CH_W-1:0]    nn;
	logic [2*CH_W:0]      nn_n;
	logic [2*GRAD_W-1:0]  gx2;
	logic [2*GRAD_W-1:0]  gy2;

	assign gx2  = (2*GRAD_W)'(gx * gx);
	assign gy2  = (2*GRAD_W)'(gy * gy);
	assign t    = n_q | bit_q;
	assign tt   = {{CH_W{1'b0}}, t} * {{CH_W{1'b0}}, t};
	assign nn   = {{CH_W{1'b0}}, n_q} * {{CH_W{1'b0}}, n_q};
	assign nn_n = {1'b0, nn} + {{(CH_W+1){1'b0}}, n_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			s_q   <= gx2[SUM_W-1:0] + gy2[SUM_W-1:0];
			n_q   <= '0;
			bit_q <= ROOT_TOP;
		end else if (ctl.step) begin
			if ({{(SUM_W-2*CH_W){1'b0}}, tt} <= s_q) begin
				n_q <= t;
			end
			bit_q <= bit_q >> 1;
		end
	end

	always_comb begin
		if (s_q > SAT_LIMIT) begin
			mag = MAG_MAX;
		end else if (s_q > {{(SUM_W-2*CH_W-1){1'b0}}, nn_n}) begin
			mag = n_q + CH_W'(1);
		end else begin
			mag = n_q;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sobel_edge_magnitude_rgb.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Two line
// stores (one RAM each) feed a row of three column cells that form the window;
// each result runs through three magnitude lanes, one per colour. A pixel's
// transfer, line store read and window shift come first; each result it then
// releases takes gradient, square, 8 steps of the bit-per-cycle square root
// and hand-over to the output register. The next pixel transfers only once
// every result of the last has entered the output register; a result waiting
// there does not block it. Writing a register restarts the frame at row 0,
// column 0. No clearing pass is needed after reset.
`default_nettype none
`include "sobel_edge_magnitude_rgb_macros.svh"
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	sem_pix_if.sink               pix,
	sem_res_if.source             res
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	state_t state_q, state_d;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	pixel_t           px_q;
	logic [CW-1:0]    col_lat_q;
	logic [ROW_W-1:0] row_lat_q;
	logic             r_ge1_q, r_ge2_q, c_zero_q;
	logic [3:0]       mask_q;
	logic [1:0]       k_q;
	logic [2:0]       step_q;

	logic [WW-1:0]    weff;
	logic [ROW_W:0]   heff;
	logic             end_col, last_row, accept;
	logic [3:0]       mask_new;
	logic [1:0]       k_sel;
	logic [3:0]       k_onehot;

	pixel_t           up_rd, mid_rd, top_px, mid_px;
	logic             ram_we;

	cell_ctl_t        ctl0, ctl1, ctl2;
	column_t          col0, col1, col2;
	column_t          cols [3];

	root_ctl_t        rctl;
	logic signed [GRAD_W-1:0] gx_q [3];
	logic signed [GRAD_W-1:0] gy_q [3];
	logic signed [GRAD_W-1:0] gx_d [3];
	logic signed [GRAD_W-1:0] gy_d [3];
	logic [CH_W-1:0]  mag [3];

	logic             out_valid_q;
	logic [CH_W-1:0]  out_r_q, out_g_q, out_b_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_last_q, out_done_q;
	logic             out_load;

	// frame geometry
	always_comb begin
		if (fw_q == '0) begin
			weff = WW'(1);
		end else if (WW'(fw_q) > WW'(MAX_WIDTH)) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = WW'(fw_q);
		end
		heff = (fh_q == '0) ? (ROW_W+1)'(1) : {1'b0, fh_q};
	end

	assign end_col   = (WW'(col_q) + WW'(1)) >= weff;
	assign last_row  = ({1'b0, row_q} + (ROW_W+1)'(1)) >= heff;
	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;

	assign mask_new[0] = (row_q != '0) && (col_q != '0);
	assign mask_new[1] = (row_q != '0) && end_col;
	assign mask_new[2] = last_row && (col_q != '0);
	assign mask_new[3] = last_row && end_col;

	// registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FRAME_WIDTH_RESET;
			fh_q  <= FRAME_HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					fw_q  <= cfg_data[FW_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					fh_q  <= cfg_data[FH_W-1:0];
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q      <= {pix.in_blue, pix.in_green, pix.in_red};
			col_lat_q <= col_q;
			row_lat_q <= row_q;
			r_ge1_q   <= (row_q != '0);
			r_ge2_q   <= (row_q > ROW_W'(1));
			c_zero_q  <= (col_q == '0);
		end
	end

	// line stores: read at transfer, write back during the load cycle
	assign ram_we = (state_q == ST_LOAD);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(ram_we), .waddr(col_lat_q), .wdata(mid_rd),
		.raddr(col_q), .rdata(up_rd)
	);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(ram_we), .waddr(col_lat_q), .wdata(px_q),
		.raddr(col_q), .rdata(mid_rd)
	);

	assign top_px = r_ge2_q ? up_rd : '0;
	assign mid_px = r_ge1_q ? mid_rd : '0;

	// window cells, shifted left once per pixel; the two left cells cleared at row start
	assign ctl0 = '{shift: ram_we, clear: c_zero_q};
	assign ctl1 = '{shift: ram_we, clear: c_zero_q};
	assign ctl2 = '{shift: ram_we, clear: 1'b0};

	sem_col_cell u_cell0 (.clk(clk), .arst_n(arst_n), .ctl(ctl0), .d(col1), .q(col0));
	sem_col_cell u_cell1 (.clk(clk), .arst_n(arst_n), .ctl(ctl1), .d(col2), .q(col1));
	sem_col_cell u_cell2 (.clk(clk), .arst_n(arst_n), .ctl(ctl2),
		.d({px_q, mid_px, top_px}), .q(col2));

	assign cols[0] = col0;
	assign cols[1] = col1;
	assign cols[2] = col2;

	// next pending result: lowest set bit of the mask
	always_comb begin
		if (mask_q[0]) begin
			k_sel = 2'd0;
		end else if (mask_q[1]) begin
			k_sel = 2'd1;
		end else if (mask_q[2]) begin
			k_sel = 2'd2;
		end else begin
			k_sel = 2'd3;
		end
		k_onehot = 4'b0001 << k_q;
	end

	// gradients of the window moved up by k_sel[1] rows, left by k_sel[0]
	always_comb begin
		logic [CH_W-1:0] sw [3][3];
		logic signed [GRAD_W-1:0] v [3][3];
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if ((i + int'(k_sel[1]) < 3) && (j + int'(k_sel[0]) < 3)) begin
						sw[i][j] = cols[j + int'(k_sel[0])][i + int'(k_sel[1])]
							[ch*CH_W +: CH_W];
					end else begin
						sw[i][j] = '0;
					end
					v[i][j] = $signed({{(GRAD_W-CH_W){1'b0}}, sw[i][j]});
				end
			end
			gx_d[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2])
				- (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
			gy_d[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2])
				- (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GRAD) begin
			gx_q <= gx_d;
			gy_q <= gy_d;
			k_q  <= k_sel;
		end
	end

	assign rctl = '{load: (state_q == ST_SQUARE), step: (state_q == ST_ROOT)};

	for (genvar g = 0; g < 3; g++) begin : g_lane
		sem_root u_root (
			.clk(clk), .ctl(rctl), .gx(gx_q[g]), .gy(gy_q[g]), .mag(mag[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mask_q <= mask_new;
			end else if (out_load) begin
				mask_q <= mask_q & ~k_onehot;
			end
			step_q <= (state_q == ST_ROOT) ? step_q + 3'd1 : '0;
		end
	end

	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || res.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = (mask_q == '0) ? ST_IDLE : ST_GRAD;
			end
			ST_GRAD: begin
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (step_q == 3'd7) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ((mask_q & ~k_onehot) == '0) ? ST_IDLE : ST_GRAD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register: holds a result while the next pixel transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_r_q    <= mag[0];
			out_g_q    <= mag[1];
			out_b_q    <= mag[2];
			out_row_q  <= k_q[1] ? row_lat_q : row_lat_q - ROW_W'(1);
			out_col_q  <= k_q[0] ? COL_W'(col_lat_q) : COL_W'(col_lat_q - CW'(1));
			out_last_q <= ((mask_q & ~k_onehot) == '0);
			out_done_q <= (k_q == 2'd3);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_red    = out_r_q;
	assign res.out_green  = out_g_q;
	assign res.out_blue   = out_b_q;
	assign res.out_row    = out_row_q;
	assign res.out_col    = out_col_q;
	assign res.run_last   = out_last_q;
	assign res.frame_done = out_done_q;

	`SEM_ASSERT_NEXT(a_accept_load, accept, state_q == ST_LOAD)
	`SEM_ASSERT_NOW(a_idle_no_pending, state_q == ST_IDLE, mask_q == '0)
	`SEM_ASSERT_NEXT(a_root_done, (state_q == ST_ROOT) && (step_q == 3'd7),
		state_q == ST_EMIT)
	`SEM_ASSERT_NOW(a_done_is_last, out_valid_q && out_done_q, out_last_q)
endmodule
`default_nettype wire
